@@ hdl/assert_macros.svh @@
// assertion helpers for the keyword detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define WWKD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define WWKD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/wwkd_pkg.sv @@
// ----------------------------------------------------------------------------
// wwkd_pkg
// shared types, keyword table and character helpers for the keyword detector
// ----------------------------------------------------------------------------
package wwkd_pkg;

    localparam int BufferBytesDefault = 1024;
    localparam int KwCount            = 9;
    localparam int KwMaxLen           = 9;
    localparam int WindowDepth        = 10;
    localparam int IndexW             = 4;

    // keywords right-aligned: last character sits in bits [7:0]
    localparam logic [KwMaxLen*8-1:0] KwText [KwCount] = '{
        (KwMaxLen*8)'("aimbot"),
        (KwMaxLen*8)'("wallhack"),
        (KwMaxLen*8)'("esp"),
        (KwMaxLen*8)'("speedhack"),
        (KwMaxLen*8)'("noclip"),
        (KwMaxLen*8)'("injector"),
        (KwMaxLen*8)'("trainer"),
        (KwMaxLen*8)'("cheat"),
        (KwMaxLen*8)'("hack")
    };

    localparam int KwLen [KwCount] = '{6, 8, 3, 9, 6, 8, 7, 5, 4};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [IndexW-1:0] keyword_index;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef logic [WindowDepth-1:0][7:0] t_window;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5a]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

endpackage

@@ hdl/wwkd_cell.sv @@
// ----------------------------------------------------------------------------
// wwkd_cell
// one byte position of the text window, loaded from its left neighbour
// ----------------------------------------------------------------------------
module wwkd_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wwkd_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]           i_byte,
    output logic [7:0]           o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

@@ hdl/wwkd_match.sv @@
// ----------------------------------------------------------------------------
// wwkd_match
// compares the window against every keyword in parallel with a left boundary
// ----------------------------------------------------------------------------
module wwkd_match (
    input  wwkd_pkg::t_window              i_window,
    output logic [wwkd_pkg::KwCount-1:0]   o_hits
);

    for (genvar k = 0; k < wwkd_pkg::KwCount; k++) begin : g_kw
        localparam int Len = wwkd_pkg::KwLen[k];
        logic [Len-1:0] w_same;

        for (genvar j = 0; j < Len; j++) begin : g_chr
            assign w_same[j] = (i_window[j] == wwkd_pkg::KwText[k][8*j +: 8]);
        end

        assign o_hits[k] = (&w_same) && !wwkd_pkg::is_word_char(i_window[Len]);
    end

endmodule

@@ hdl/whole_word_keyword_detector.sv @@
// ----------------------------------------------------------------------------
// whole_word_keyword_detector
// whole-word search for nine fixed keywords in a byte stream
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while i_in_valid is high and the input
// is not stalled. Bytes are case folded and shifted through a row of nine
// cells that, together with the incoming byte, form a ten-byte window; all
// nine keywords are compared against the window in the same cycle and a hit
// is confirmed once the following byte (or the end of the text) is seen to
// be non-alphanumeric. A zero byte or reaching BUFFER_BYTES-1 bytes closes
// the text. The registered result follows in the cycle after the final byte
// is taken; a final byte is held off only while an earlier result is stalled.
module whole_word_keyword_detector #(
    parameter int BUFFER_BYTES = wwkd_pkg::BufferBytesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wwkd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wwkd_pkg::t_out_item o_out_data
);

    `include "assert_macros.svh"

    localparam int KwCount     = wwkd_pkg::KwCount;
    localparam int WindowDepth = wwkd_pkg::WindowDepth;
    localparam int IndexW      = wwkd_pkg::IndexW;
    localparam int CountW      = $clog2(BUFFER_BYTES);
    localparam logic [CountW-1:0] CountLimit = CountW'(BUFFER_BYTES - 1);

    logic                        w_accept;
    logic                        w_last;
    logic [7:0]                  w_char;
    logic                        w_text_end;
    logic                        w_take;
    wwkd_pkg::t_cell_ctl         w_ctl;
    logic [WindowDepth-2:0][7:0] w_cell_q;
    wwkd_pkg::t_window           w_window;
    logic [KwCount-1:0]          w_hits;
    logic [KwCount-1:0]          w_step_matched;
    logic [KwCount-1:0]          w_step_pending;
    logic [KwCount-1:0]          w_final_set;
    logic [IndexW-1:0]           w_index;

    logic [KwCount-1:0]   r_pending, n_pending;
    logic [KwCount-1:0]   r_matched, n_matched;
    logic                 r_closed, n_closed;
    logic [CountW-1:0]    r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    wwkd_pkg::t_out_item  r_out_data, n_out_data;

    assign o_in_stall = r_out_valid && i_out_stall && i_in_data.final_byte;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_last     = i_in_data.final_byte;
    assign w_char     = wwkd_pkg::fold_byte(i_in_data.text_byte);
    assign w_text_end = !r_closed && ((i_in_data.text_byte == 8'd0) || (r_count == CountLimit));
    assign w_take     = !r_closed && !w_text_end;

    assign w_ctl.shift = w_accept && w_take;
    assign w_ctl.clear = w_accept && w_last;

    // window cells
    assign w_window[0] = w_char;

    for (genvar i = 0; i < WindowDepth - 1; i++) begin : g_cell
        if (i == 0) begin : g_head
            wwkd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_byte  (w_char),
                .o_byte  (w_cell_q[i])
            );
        end else begin : g_body
            wwkd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_byte  (w_cell_q[i-1]),
                .o_byte  (w_cell_q[i])
            );
        end
        assign w_window[i+1] = w_cell_q[i];
    end

    wwkd_match u_match (
        .i_window (w_window),
        .o_hits   (w_hits)
    );

    assign w_step_matched = r_matched |
        ((w_text_end || (w_take && !wwkd_pkg::is_word_char(w_char))) ? r_pending : '0);
    assign w_step_pending = w_take ? w_hits : '0;
    assign w_final_set    = w_step_matched | w_step_pending;

    always_comb begin
        w_index = '0;
        for (int k = KwCount - 1; k >= 0; k--) begin
            if (w_final_set[k]) begin
                w_index = IndexW'(k);
            end
        end
    end

    always_comb begin
        n_pending   = r_pending;
        n_matched   = r_matched;
        n_closed    = r_closed;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (w_accept) begin
            if (w_last) begin
                n_pending                = '0;
                n_matched                = '0;
                n_closed                 = 1'b0;
                n_count                  = '0;
                n_out_valid              = 1'b1;
                n_out_data.found         = |w_final_set;
                n_out_data.keyword_index = w_index;
            end else begin
                n_pending = w_step_pending;
                n_matched = w_step_matched;
                n_closed  = r_closed || w_text_end;
                if (w_take) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_matched   <= '0;
            r_closed    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_matched   <= n_matched;
            r_closed    <= n_closed;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `WWKD_ASSERT(a_result_follows_final, i_clk, i_rst_n, (w_accept && w_last) |=> r_out_valid, "no result after final byte")
    `WWKD_ASSERT(a_state_cleared_after_final, i_clk, i_rst_n, (w_accept && w_last) |=> (r_count == '0 && !r_closed && r_matched == '0), "text state not cleared")
    `WWKD_ASSERT(a_no_pending_when_closed, i_clk, i_rst_n, r_closed |-> (r_pending == '0), "pending hits on closed text")
    `WWKD_ASSERT(a_head_cell_loads, i_clk, i_rst_n, (w_accept && w_take && !w_last) |=> (w_cell_q[0] == $past(w_char)), "head cell did not load byte")
    `WWKD_ASSERT_ALWAYS(a_count_bounded, i_clk, !i_rst_n || (r_count <= CountLimit), "byte count past limit")

endmodule
